@@ hw/rtl/yskin_pkg.sv @@
// Shared constants and types for the YCrCb skin pixel classifier.
package yskin_pkg;

  // Luma weights, 14-bit fixed point
  localparam logic [13:0] LumaWr = 14'd4899;
  localparam logic [13:0] LumaWg = 14'd9617;
  localparam logic [13:0] LumaWb = 14'd1868;

  // Chroma gains
  localparam logic [13:0] GainCr = 14'd11682;
  localparam logic [13:0] GainCb = 14'd9241;

  localparam logic [21:0]        FixHalf    = 22'd8192;
  // (128 << 14) + rounding half
  localparam logic signed [23:0] ChromaBias = 24'sd2105344;

  typedef enum logic [2:0] {
    REG_LUMA_MIN  = 3'd0,
    REG_LUMA_MAX  = 3'd1,
    REG_CR_MIN    = 3'd2,
    REG_CR_MAX    = 3'd3,
    REG_CB_MIN    = 3'd4,
    REG_CB_MAX    = 3'd5
  } cfg_idx_e;

  localparam logic [7:0] RstLumaMin = 8'd100;
  localparam logic [7:0] RstLumaMax = 8'd255;
  localparam logic [7:0] RstCrMin   = 8'd160;
  localparam logic [7:0] RstCrMax   = 8'd190;
  localparam logic [7:0] RstCbMin   = 8'd70;
  localparam logic [7:0] RstCbMax   = 8'd100;

  // Load enables for the two chroma stages
  typedef struct packed {
    logic mul_en;
    logic sat_en;
  } chroma_en_t;

endpackage

@@ hw/rtl/yskin_if.sv @@
// Handshake interfaces: pixel in, mask out, register write.
interface yskin_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  modport source (output valid, blue, green, red, input ready);
  modport sink   (input valid, blue, green, red, output ready);
endinterface

interface yskin_mask_if;
  logic valid;
  logic ready;
  logic skin;
  modport source (output valid, skin, input ready);
  modport sink   (input valid, skin, output ready);
endinterface

interface yskin_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/yskin_chroma.sv @@
// One chroma channel: gain multiply stage, then bias, shift and clamp stage.
module yskin_chroma (
  input  logic                   clk_i,
  input  yskin_pkg::chroma_en_t  en_i,
  input  logic signed [8:0]      diff_i,
  input  logic [13:0]            gain_i,
  output logic [7:0]             chroma_o
);

  logic signed [14:0] gain_s;
  logic signed [23:0] prod_d, prod_q;
  logic signed [23:0] biased;
  logic [7:0]         chroma_d, chroma_q;

  assign gain_s = signed'({1'b0, gain_i});
  assign prod_d = diff_i * gain_s;

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  assign biased = prod_q + yskin_pkg::ChromaBias;

  // negative -> 0, quotient above 255 -> 255
  always_comb begin
    if (biased[23]) begin
      chroma_d = 8'd0;
    end else if (biased[22]) begin
      chroma_d = 8'd255;
    end else begin
      chroma_d = biased[21:14];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sat_en) begin
      chroma_q <= chroma_d;
    end
  end

  assign chroma_o = chroma_q;

endmodule

@@ hw/rtl/ycrcb_skin_pixel_classifier.sv @@
// Top level: BGR pixel to YCrCb, three range tests, two-of-three skin vote.
//
//  channel | modport | beat carries        | accepted when
//  --------+---------+---------------------+-------------------
//  pix_i   | sink    | blue, green, red    | valid && ready
//  cfg_i   | sink    | index, data         | valid && ready
//  mask_o  | source  | skin                | valid && ready
//
// Five register stages: luma products, luma sum and differences, chroma
// products, chroma clamp, range vote. One pixel per cycle sustained while
// mask_o is ready. Each stage has its own valid bit and loads when empty or
// when the stage after it moves, so bubbles close up and a stall at mask_o
// holds every beat in place. rst_ni clears valid bits and sets the bound
// registers to their defaults; cfg_i is always ready.
module ycrcb_skin_pixel_classifier (
  input  logic         clk_i,
  input  logic         rst_ni,
  yskin_pix_if.sink    pix_i,
  yskin_cfg_if.sink    cfg_i,
  yskin_mask_if.source mask_o
);

  // ---------------- bound registers ----------------
  logic [7:0] luma_min_q, luma_max_q, cr_min_q, cr_max_q, cb_min_q, cb_max_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_min_q <= yskin_pkg::RstLumaMin;
      luma_max_q <= yskin_pkg::RstLumaMax;
      cr_min_q   <= yskin_pkg::RstCrMin;
      cr_max_q   <= yskin_pkg::RstCrMax;
      cb_min_q   <= yskin_pkg::RstCbMin;
      cb_max_q   <= yskin_pkg::RstCbMax;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        yskin_pkg::REG_LUMA_MIN: luma_min_q <= cfg_i.data;
        yskin_pkg::REG_LUMA_MAX: luma_max_q <= cfg_i.data;
        yskin_pkg::REG_CR_MIN:   cr_min_q   <= cfg_i.data;
        yskin_pkg::REG_CR_MAX:   cr_max_q   <= cfg_i.data;
        yskin_pkg::REG_CB_MIN:   cb_min_q   <= cfg_i.data;
        yskin_pkg::REG_CB_MAX:   cb_max_q   <= cfg_i.data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  logic [4:0] vld_q, vld_d;
  logic [4:0] load;

  // stage k loads when empty or when stage k+1 takes its beat
  assign load[4] = !vld_q[4] || mask_o.ready;
  assign load[3] = !vld_q[3] || load[4];
  assign load[2] = !vld_q[2] || load[3];
  assign load[1] = !vld_q[1] || load[2];
  assign load[0] = !vld_q[0] || load[1];

  assign pix_i.ready = load[0];

  always_comb begin
    vld_d = vld_q;
    if (load[0]) vld_d[0] = pix_i.valid;
    if (load[1]) vld_d[1] = vld_q[0];
    if (load[2]) vld_d[2] = vld_q[1];
    if (load[3]) vld_d[3] = vld_q[2];
    if (load[4]) vld_d[4] = vld_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // ---------------- stage 1: luma products ----------------
  logic [21:0] pr_q, pg_q, pb_q;
  logic [7:0]  r1_q, b1_q;

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      pr_q <= 22'(pix_i.red)   * 22'(yskin_pkg::LumaWr);
      pg_q <= 22'(pix_i.green) * 22'(yskin_pkg::LumaWg);
      pb_q <= 22'(pix_i.blue)  * 22'(yskin_pkg::LumaWb);
      r1_q <= pix_i.red;
      b1_q <= pix_i.blue;
    end
  end

  // ---------------- stage 2: luma, color differences ----------------
  // sum peaks just under 2^22, so Y is bits 21:14
  logic [21:0]       ysum;
  logic [7:0]        y2_q;
  logic signed [8:0] dr_q, db_q;

  assign ysum = pr_q + pg_q + pb_q + yskin_pkg::FixHalf;

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      y2_q <= ysum[21:14];
      dr_q <= signed'({1'b0, r1_q}) - signed'({1'b0, ysum[21:14]});
      db_q <= signed'({1'b0, b1_q}) - signed'({1'b0, ysum[21:14]});
    end
  end

  // ---------------- stages 3-4: chroma ----------------
  yskin_pkg::chroma_en_t cen;
  logic [7:0] y3_q, y4_q;
  logic [7:0] cr4, cb4;

  assign cen.mul_en = load[2];
  assign cen.sat_en = load[3];

  yskin_chroma u_cr (
    .clk_i    (clk_i),
    .en_i     (cen),
    .diff_i   (dr_q),
    .gain_i   (yskin_pkg::GainCr),
    .chroma_o (cr4)
  );

  yskin_chroma u_cb (
    .clk_i    (clk_i),
    .en_i     (cen),
    .diff_i   (db_q),
    .gain_i   (yskin_pkg::GainCb),
    .chroma_o (cb4)
  );

  always_ff @(posedge clk_i) begin
    if (load[2]) y3_q <= y2_q;
    if (load[3]) y4_q <= y3_q;
  end

  // ---------------- stage 5: range tests and vote ----------------
  // inverted bounds (min > max) can never pass
  logic pass_y, pass_cr, pass_cb;
  logic skin_q;

  assign pass_y  = (y4_q >= luma_min_q) && (y4_q <= luma_max_q);
  assign pass_cr = (cr4  >= cr_min_q)   && (cr4  <= cr_max_q);
  assign pass_cb = (cb4  >= cb_min_q)   && (cb4  <= cb_max_q);

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      skin_q <= (pass_y & pass_cr) | (pass_y & pass_cb) | (pass_cr & pass_cb);
    end
  end

  assign mask_o.valid = vld_q[4];
  assign mask_o.skin  = skin_q;

endmodule

@@ sim/ycrcb_skin_pixel_classifier_checker.sv @@
// Checker for the skin classifier: predicts the mask of every accepted pixel and compares.
`timescale 1ns / 1ps

module ycrcb_skin_pixel_classifier_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  yskin_pix_if        pix_i,
  yskin_cfg_if        cfg_i,
  yskin_mask_if       mask_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);

  // 14-bit fixed point BGR to YCrCb
  localparam int FracBits    = 14;
  localparam int RoundHalf   = 8192;
  localparam int ChromaZero  = (128 << FracBits) + RoundHalf;
  localparam int LumaWtR     = 4899;
  localparam int LumaWtG     = 9617;
  localparam int LumaWtB     = 1868;
  localparam int CrGain      = 11682;
  localparam int CbGain      = 9241;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       skin;
  } skin_expect_t;

  skin_expect_t skin_expect_q[$];
  skin_expect_t oldest;
  logic [7:0]   luma_lo, luma_hi, cr_lo, cr_hi, cb_lo, cb_hi;
  int unsigned  mismatch_cnt = 0;
  int unsigned  pending;

  assign mismatch_cnt_o = mismatch_cnt;
  assign pending_o      = pending;

  function automatic int clamp_chroma(input int diff, input int gain);
    int v;
    v = diff * gain + ChromaZero;
    if (v < 0) return 0;
    v = v >>> FracBits;
    return (v > 255) ? 255 : v;
  endfunction

  // Two-of-three vote over the luma, Cr and Cb windows
  function automatic logic classify_pixel(input logic [7:0] b, input logic [7:0] g,
                                          input logic [7:0] r);
    int luma, cr, cb, votes;
    luma  = (LumaWtR * int'(r) + LumaWtG * int'(g) + LumaWtB * int'(b) + RoundHalf)
            >>> FracBits;
    cr    = clamp_chroma(int'(r) - luma, CrGain);
    cb    = clamp_chroma(int'(b) - luma, CbGain);
    votes = 0;
    if (luma >= int'(luma_lo) && luma <= int'(luma_hi)) votes++;
    if (cr >= int'(cr_lo) && cr <= int'(cr_hi)) votes++;
    if (cb >= int'(cb_lo) && cb <= int'(cb_hi)) votes++;
    return votes >= 2;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_lo <= 8'd100;
      luma_hi <= 8'd255;
      cr_lo   <= 8'd160;
      cr_hi   <= 8'd190;
      cb_lo   <= 8'd70;
      cb_hi   <= 8'd100;
      skin_expect_q.delete();
      pending <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          yskin_pkg::REG_LUMA_MIN: luma_lo <= cfg_i.data;
          yskin_pkg::REG_LUMA_MAX: luma_hi <= cfg_i.data;
          yskin_pkg::REG_CR_MIN:   cr_lo   <= cfg_i.data;
          yskin_pkg::REG_CR_MAX:   cr_hi   <= cfg_i.data;
          yskin_pkg::REG_CB_MIN:   cb_lo   <= cfg_i.data;
          yskin_pkg::REG_CB_MAX:   cb_hi   <= cfg_i.data;
          default: ;  // unmapped index, no effect
        endcase
      end
      if (pix_i.valid && pix_i.ready) begin
        skin_expect_q.push_back('{blue: pix_i.blue, green: pix_i.green, red: pix_i.red,
                                  skin: classify_pixel(pix_i.blue, pix_i.green, pix_i.red)});
      end
      if (mask_i.valid && mask_i.ready) begin
        if (skin_expect_q.size() == 0) begin
          report_mismatch($sformatf("mask beat skin=%b with no pixel pending", mask_i.skin));
        end else begin
          oldest = skin_expect_q.pop_front();
          if (mask_i.skin !== oldest.skin)
            report_mismatch($sformatf("pixel b=%0d g=%0d r=%0d: skin=%b, want %b",
                                      oldest.blue, oldest.green, oldest.red,
                                      mask_i.skin, oldest.skin));
        end
      end
      pending <= skin_expect_q.size();
    end
  end

endmodule

@@ sim/ycrcb_skin_pixel_classifier_test.sv @@
// Top of the skin classifier bench: clock, reset, pixel and register stimulus, verdict.
`timescale 1ns / 1ps

module ycrcb_skin_pixel_classifier_test;

  // Register stages in the block; the tail wait after the drain scales with it.
  localparam int unsigned PipeDepth  = 5;
  // Watchdog limit, far beyond the slowest legal run.
  localparam int unsigned CycleLimit = 200000;
  // Register indexes with no register behind them
  localparam logic [2:0] IdxUnmapped0 = 3'd6;
  localparam logic [2:0] IdxUnmapped1 = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned tx_gap_pct;     // chance per cycle that the pixel source holds off
  int unsigned rx_stall_pct;   // chance per cycle that the mask sink is not ready
  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt;
  int unsigned pending;

  yskin_pix_if  pix_bus ();
  yskin_cfg_if  cfg_bus ();
  yskin_mask_if mask_bus ();

  ycrcb_skin_pixel_classifier uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_bus),
    .cfg_i  (cfg_bus),
    .mask_o (mask_bus)
  );

  ycrcb_skin_pixel_classifier_checker mask_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_i          (pix_bus),
    .cfg_i          (cfg_bus),
    .mask_i         (mask_bus),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost mask beat ends here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("** ycrcb_skin_pixel_classifier: FAILED **");
      $finish;
    end
  end

  // Mask sink back-pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    mask_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // One pixel beat. Valid is left high on return so back-to-back beats
  // never see a low/high pair in one time step; the next call or a drain
  // decides what happens to it.
  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
    while ($urandom_range(99) < tx_gap_pct) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.blue  <= b;
    pix_bus.green <= g;
    pix_bus.red   <= r;
    do @(posedge clk_i); while (!pix_bus.ready);
  endtask

  // Stop sending and wait until every predicted mask beat has come back.
  // pending is registered in the checker, so it is read after an edge.
  task automatic wait_drained();
    pix_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Register write beat; valid is left high for a following write.
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
  endtask

  task automatic write_bounds(input logic [7:0] y_lo, input logic [7:0] y_hi,
                              input logic [7:0] r_lo, input logic [7:0] r_hi,
                              input logic [7:0] b_lo, input logic [7:0] b_hi);
    write_reg(yskin_pkg::REG_LUMA_MIN, y_lo);
    write_reg(yskin_pkg::REG_LUMA_MAX, y_hi);
    write_reg(yskin_pkg::REG_CR_MIN,   r_lo);
    write_reg(yskin_pkg::REG_CR_MAX,   r_hi);
    write_reg(yskin_pkg::REG_CB_MIN,   b_lo);
    write_reg(yskin_pkg::REG_CB_MAX,   b_hi);
    cfg_bus.valid <= 1'b0;
  endtask

  // Random pixels: half uniform, a quarter skin-like (red over green over
  // blue) so the Cr/Cb windows actually vote, a quarter near the rails.
  task automatic run_batch(input int unsigned n);
    logic [7:0]  b, g, r;
    int unsigned mode;
    for (int unsigned i = 0; i < n; i++) begin
      mode = $urandom_range(3);
      case (mode)
        0, 1: begin
          b = 8'($urandom);
          g = 8'($urandom);
          r = 8'($urandom);
        end
        2: begin
          r = 8'($urandom_range(255, 110));
          g = 8'(r - $urandom_range(90, 15));
          b = 8'(g - $urandom_range((g < 70) ? g : 70, 0));
        end
        default: begin
          b = $urandom_range(1) ? 8'(255 - $urandom_range(1)) : 8'($urandom_range(1));
          g = $urandom_range(1) ? 8'(255 - $urandom_range(1)) : 8'($urandom_range(1));
          r = $urandom_range(1) ? 8'(255 - $urandom_range(1)) : 8'($urandom_range(1));
        end
      endcase
      send_pixel(b, g, r);
    end
  endtask

  initial begin
    logic [7:0] lo, hi;
    logic [7:0] bnd [6];

    rst_ni         <= 1'b0;
    pix_bus.valid  <= 1'b0;
    pix_bus.blue   <= 8'd0;
    pix_bus.green  <= 8'd0;
    pix_bus.red    <= 8'd0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= yskin_pkg::REG_LUMA_MIN;
    cfg_bus.data   <= 8'd0;
    tx_gap_pct   = 17;
    rx_stall_pct = 52;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, default windows: black, white, primaries and their mixes
    // (pure red drives Cr past 255 and must clamp), mid gray, skin tones.
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd120, 8'd150, 8'd200);
    send_pixel(8'd90,  8'd130, 8'd220);
    send_pixel(8'd60,  8'd80,  8'd180);
    send_pixel(8'd140, 8'd170, 8'd230);
    send_pixel(8'd1,   8'd254, 8'd1);

    run_batch(125);
    // Source holds off until the pipe is empty, then resumes.
    wait_drained();
    run_batch(125);

    // Fully open windows: every pixel is skin. Unmapped indexes are written
    // first with large values that would close a window if they aliased.
    wait_drained();
    write_reg(IdxUnmapped0, 8'($urandom_range(255, 200)));
    write_reg(IdxUnmapped1, 8'($urandom_range(255, 200)));
    write_bounds(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
    run_batch(120);

    // Every window inverted: no channel passes, nothing is skin.
    wait_drained();
    tx_gap_pct   = 52;
    rx_stall_pct = 17;
    write_bounds(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
    run_batch(100);

    // Random windows, now and then an inverted one.
    for (int k = 0; k < 3; k++) begin
      wait_drained();
      if (k == 2) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
      for (int c = 0; c < 3; c++) begin
        lo = 8'($urandom_range(200, 0));
        hi = 8'($urandom_range(255, lo));
        if ($urandom_range(4) == 0) begin
          bnd[2*c]   = hi;
          bnd[2*c+1] = lo;
        end else begin
          bnd[2*c]   = lo;
          bnd[2*c+1] = hi;
        end
      end
      write_bounds(bnd[0], bnd[1], bnd[2], bnd[3], bnd[4], bnd[5]);
      run_batch(150);
    end

    // Back to the power-up windows at full rate.
    wait_drained();
    write_bounds(8'd100, 8'd255, 8'd160, 8'd190, 8'd70, 8'd100);
    run_batch(220);

    wait_drained();
    repeat (4 * PipeDepth) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** ycrcb_skin_pixel_classifier: PASSED **");
    end else begin
      $display("** ycrcb_skin_pixel_classifier: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/yskin_pkg.sv
hw/rtl/yskin_if.sv
hw/rtl/yskin_chroma.sv
hw/rtl/ycrcb_skin_pixel_classifier.sv
sim/ycrcb_skin_pixel_classifier_checker.sv
sim/ycrcb_skin_pixel_classifier_test.sv
